FILE: rtl/tem_pkg.sv
`timescale 1ns / 1ps

package tem_pkg;

  // table geometry
  localparam int FONT_SLOTS    = 4;
  localparam int GLYPH_ENTRIES = 256;
  localparam int FONT_W        = 2;
  localparam int GLYPH_W       = $clog2(GLYPH_ENTRIES);
  localparam int TABLE_DEPTH   = FONT_SLOTS * GLYPH_ENTRIES;
  localparam int TABLE_AW      = $clog2(TABLE_DEPTH);
  localparam int RECODE_W      = 8;
  localparam int WIDTH_W       = 4;

  // item modes
  localparam logic [1:0] MODE_TEXT   = 2'd0;
  localparam logic [1:0] MODE_RECODE = 2'd1;
  localparam logic [1:0] MODE_WIDTH  = 2'd2;
  localparam logic [1:0] MODE_ATTR   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_START_X      = 2'd0;
  localparam logic [1:0] CFG_START_Y      = 2'd1;
  localparam logic [1:0] CFG_INITIAL_FONT = 2'd2;

  // control bytes in the text stream
  localparam logic [7:0] CH_END     = 8'h00;
  localparam logic [7:0] CH_FONT    = 8'h01;
  localparam logic [7:0] CH_MOVE    = 8'h02;
  localparam logic [7:0] CH_SKIP    = 8'h03;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  // attribute bits and glyph limits
  localparam int          ATTR_RECODE7 = 0;
  localparam int          ATTR_PROP    = 1;
  localparam logic [7:0]  MASK_7BIT    = 8'h7f;
  localparam logic [7:0]  MASK_8BIT    = 8'hff;
  localparam logic [7:0]  MAX_WIDTH    = 8'd8;
  localparam logic [4:0]  TILE_PIXELS  = 5'd7;

  typedef enum logic [2:0] {
    PH_NORMAL,
    PH_FONT,
    PH_ROW,
    PH_COL,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_GLYPH,
    OP_END,
    OP_CLOSE,
    OP_NEWLINE,
    OP_ROW,
    OP_COL
  } op_t;

  typedef struct packed {
    logic       any;
    logic [7:0] min_col;
    logic [7:0] min_row;
    logic [7:0] max_col;
    logic [7:0] max_row;
  } box_t;

  // widen the bounding box by one cell, 8-bit wrap on the far edge
  function automatic box_t include_cell(box_t b, logic [7:0] c, logic [7:0] r);
    box_t       n;
    logic [7:0] c1;
    logic [7:0] r1;
    c1 = c + 8'd1;
    r1 = r + 8'd1;
    n  = b;
    if (!b.any) begin
      n.any     = 1'b1;
      n.min_col = c;
      n.min_row = r;
      n.max_col = c1;
      n.max_row = r1;
    end else begin
      if (c < b.min_col) n.min_col = c;
      if (r < b.min_row) n.min_row = r;
      if (c1 > b.max_col) n.max_col = c1;
      if (r1 > b.max_row) n.max_row = r1;
    end
    return n;
  endfunction

endpackage

FILE: rtl/tem_if.sv
`timescale 1ns / 1ps

// text and table-write items
interface tem_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] font_select;
  logic [7:0] table_index;
  logic [7:0] data_byte;

  modport source (output valid, mode, font_select, table_index, data_byte, input ready);
  modport sink   (input valid, mode, font_select, table_index, data_byte, output ready);
endinterface

// measurement results
interface tem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tiles_used;
  logic [7:0] box_x;
  logic [7:0] box_y;
  logic [7:0] box_width;
  logic [7:0] box_height;

  modport source (output valid, tiles_used, box_x, box_y, box_width, box_height,
                  input ready);
  modport sink   (input valid, tiles_used, box_x, box_y, box_width, box_height,
                  output ready);
endinterface

// register writes
interface tem_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/tem_ram.sv
`timescale 1ns / 1ps

module tem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // one write port, one registered read port, read returns old data on a collision
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/text_extent_measure.sv
`timescale 1ns / 1ps

// Text extent measurement for a variable-width tile font.
// Channels: in_chan takes text bytes and table writes (recode, width,
// font attributes), out_chan returns tile count and bounding box, cfg_chan
// writes start_x, start_y and initial_font (index 0, 1, 2; always ready).
// Table writes and text bytes share the input channel and are taken in order.
// One item is accepted per cycle while the input channel is not held. A
// text byte runs through three stages: recode table read, width table
// read, then the layout update. A zero byte goes through s1, s2 and the
// result register to out_chan. Throughput is one item per cycle when not
// held; the two registered table reads are pipelined behind the byte parser.
// Reset clears the attributes, start registers and layout state; the recode
// and width tables hold garbage until written. A register write restarts the
// current string from the new start.
// When the receiver stalls, the result waits in the output register and
// items keep flowing; only a second terminating byte reaching the last stage
// holds the input channel until the waiting result is taken.
module text_extent_measure
  import tem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tem_in_if.sink      in_chan,
  tem_out_if.source   out_chan,
  tem_cfg_if.sink     cfg_chan
);

  // configuration registers
  logic [7:0]        start_x_r, start_x_nxt;
  logic [7:0]        start_y_r, start_y_nxt;
  logic [FONT_W-1:0] init_font_r, init_font_nxt;
  logic              cfg_wr;

  // front parser state
  phase_t            phase_r, phase_nxt;
  logic [FONT_W-1:0] active_font_r, active_font_nxt;
  logic [1:0]        font_flags_r [FONT_SLOTS];
  op_t               front_op;

  // pipeline stages
  logic              s1_valid_r, s2_valid_r;
  op_t               s1_op_r, s2_op_r;
  logic [7:0]        s1_d_r, s2_d_r;
  logic              s1_prop_r, s2_prop_r;
  logic [FONT_W-1:0] s1_font_r;

  // layout state
  logic [7:0]        tiles_r, tiles_nxt;
  logic [2:0]        pix_r, pix_nxt;
  logic [7:0]        col_r, col_nxt;
  logic [7:0]        row_r, row_nxt;
  logic [7:0]        line_col_r, line_col_nxt;
  box_t              box_r, box_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_tiles_r, out_x_r, out_y_r, out_w_r, out_h_r;

  // handshake
  logic              advance, in_accept, text_accept, step, emit;
  logic [1:0]        cur_flags;

  // tables
  logic                wr_fs_ok;
  logic                recode_we, width_we;
  logic [TABLE_AW-1:0] wr_addr, recode_rd_addr, width_rd_addr;
  logic [RECODE_W-1:0] recode_rd_data;
  logic [WIDTH_W-1:0]  width_rd_data, width_wr_data;
  logic [7:0]          char_masked;
  logic [4:0]          off_sum;

  // only a terminating byte in the last stage can be blocked by the output register
  assign emit        = s2_valid_r && (s2_op_r == OP_END);
  assign advance     = !(emit && out_valid_r && !out_chan.ready);
  assign in_chan.ready = advance;
  assign in_accept   = in_chan.valid && advance;
  assign text_accept = in_accept && (in_chan.mode == MODE_TEXT);
  assign step        = advance && s2_valid_r;
  assign cfg_chan.ready = 1'b1;
  assign cfg_wr      = cfg_chan.valid;

  // configuration next values
  always_comb begin
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    init_font_nxt = init_font_r;
    if (cfg_wr) begin
      case (cfg_chan.index)
        CFG_START_X:      start_x_nxt   = cfg_chan.data;
        CFG_START_Y:      start_y_nxt   = cfg_chan.data;
        CFG_INITIAL_FONT: init_font_nxt = cfg_chan.data[FONT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r   <= '0;
      start_y_r   <= '0;
      init_font_r <= '0;
    end else begin
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      init_font_r <= init_font_nxt;
    end
  end

  // parser next state
  always_comb begin
    phase_nxt       = phase_r;
    active_font_nxt = active_font_r;
    if (text_accept) begin
      case (phase_r)
        PH_FONT: begin
          if (32'(in_chan.data_byte) < FONT_SLOTS)
            active_font_nxt = in_chan.data_byte[FONT_W-1:0];
          phase_nxt = PH_NORMAL;
        end
        PH_ROW:  phase_nxt = PH_COL;
        PH_COL:  phase_nxt = PH_NORMAL;
        PH_SKIP: phase_nxt = PH_NORMAL;
        default: begin
          phase_nxt = PH_NORMAL;
          case (in_chan.data_byte)
            CH_END:  active_font_nxt = init_font_r;
            CH_FONT: phase_nxt = PH_FONT;
            CH_MOVE: phase_nxt = PH_ROW;
            CH_SKIP: phase_nxt = PH_SKIP;
            default: ;
          endcase
        end
      endcase
    end
  end

  // parser output: operation handed to the layout stages
  always_comb begin
    front_op = OP_NONE;
    if (text_accept) begin
      case (phase_r)
        PH_ROW:  front_op = OP_ROW;
        PH_COL:  front_op = OP_COL;
        PH_NORMAL: begin
          case (in_chan.data_byte)
            CH_END:     front_op = OP_END;
            CH_FONT:    front_op = OP_NONE;
            CH_MOVE:    front_op = OP_CLOSE;
            CH_SKIP:    front_op = OP_NONE;
            CH_NEWLINE: front_op = OP_NEWLINE;
            default:    front_op = OP_GLYPH;
          endcase
        end
        default: front_op = OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_NORMAL;
      active_font_r <= '0;
    end else if (cfg_wr) begin
      phase_r       <= PH_NORMAL;
      active_font_r <= init_font_nxt;
    end else begin
      phase_r       <= phase_nxt;
      active_font_r <= active_font_nxt;
    end
  end

  // font attribute bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FONT_SLOTS; i++) font_flags_r[i] <= '0;
    end else if (in_accept && in_chan.mode == MODE_ATTR && wr_fs_ok) begin
      font_flags_r[in_chan.font_select] <= in_chan.data_byte[1:0];
    end
  end

  // table writes and the recode lookup
  assign wr_fs_ok      = 32'(in_chan.font_select) < FONT_SLOTS;
  assign wr_addr       = {in_chan.font_select, in_chan.table_index[GLYPH_W-1:0]};
  assign recode_we     = in_accept && in_chan.mode == MODE_RECODE && wr_fs_ok;
  assign width_we      = in_accept && in_chan.mode == MODE_WIDTH && wr_fs_ok;
  assign width_wr_data = (in_chan.data_byte > MAX_WIDTH) ? MAX_WIDTH[WIDTH_W-1:0]
                                                         : in_chan.data_byte[WIDTH_W-1:0];
  assign cur_flags      = font_flags_r[active_font_r];
  assign char_masked    = in_chan.data_byte & (cur_flags[ATTR_RECODE7] ? MASK_7BIT : MASK_8BIT);
  assign recode_rd_addr = {active_font_r, char_masked[GLYPH_W-1:0]};
  assign width_rd_addr  = {s1_font_r, recode_rd_data[GLYPH_W-1:0]};

  tem_ram #(
    .WIDTH (RECODE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_recode_ram (
    .clk     (clk),
    .wr_en   (recode_we),
    .wr_addr (wr_addr),
    .wr_data (in_chan.data_byte),
    .rd_en   (advance),
    .rd_addr (recode_rd_addr),
    .rd_data (recode_rd_data)
  );

  tem_ram #(
    .WIDTH (WIDTH_W),
    .DEPTH (TABLE_DEPTH)
  ) u_width_ram (
    .clk     (clk),
    .wr_en   (width_we),
    .wr_addr (wr_addr),
    .wr_data (width_wr_data),
    .rd_en   (advance),
    .rd_addr (width_rd_addr),
    .rd_data (width_rd_data)
  );

  // stage registers, control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= (front_op != OP_NONE);
      s2_valid_r <= s1_valid_r;
    end
  end

  // stage registers, payload
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r   <= front_op;
      s1_d_r    <= in_chan.data_byte;
      s1_prop_r <= cur_flags[ATTR_PROP];
      s1_font_r <= active_font_r;
      s2_op_r   <= s1_op_r;
      s2_d_r    <= s1_d_r;
      s2_prop_r <= s1_prop_r;
    end
  end

  // layout update for the item in the last stage
  assign off_sum = {2'b00, pix_r} + {1'b0, width_rd_data};

  always_comb begin
    tiles_nxt    = tiles_r;
    pix_nxt      = pix_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    line_col_nxt = line_col_r;
    box_nxt      = box_r;
    if (step) begin
      case (s2_op_r)
        OP_GLYPH: begin
          if (s2_prop_r) begin
            if (off_sum > TILE_PIXELS) begin
              tiles_nxt = tiles_r + 8'd1;
              box_nxt   = include_cell(box_r, col_r, row_r);
              col_nxt   = col_r + 8'd1;
            end
            pix_nxt = off_sum[2:0];
            if (off_sum[2:0] != 3'd0) box_nxt = include_cell(box_nxt, col_nxt, row_r);
          end else begin
            tiles_nxt = tiles_r + 8'd1;
            pix_nxt   = 3'd0;
            box_nxt   = include_cell(box_r, col_r, row_r);
            col_nxt   = col_r + 8'd1;
          end
        end
        OP_END: begin
          tiles_nxt    = '0;
          pix_nxt      = '0;
          col_nxt      = start_x_r;
          row_nxt      = start_y_r;
          line_col_nxt = start_x_r;
          box_nxt      = '{any: 1'b0, min_col: start_x_r, min_row: start_y_r,
                           max_col: start_x_r, max_row: start_y_r};
        end
        OP_CLOSE: begin
          if (pix_r != 3'd0) tiles_nxt = tiles_r + 8'd1;
          pix_nxt = '0;
        end
        OP_NEWLINE: begin
          if (pix_r != 3'd0) tiles_nxt = tiles_r + 8'd1;
          pix_nxt = '0;
          row_nxt = row_r + 8'd1;
          col_nxt = line_col_r;
        end
        OP_ROW: row_nxt = s2_d_r;
        OP_COL: begin
          col_nxt      = s2_d_r;
          line_col_nxt = s2_d_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tiles_r    <= '0;
      pix_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
      line_col_r <= '0;
      box_r      <= '0;
    end else if (cfg_wr) begin
      tiles_r    <= '0;
      pix_r      <= '0;
      col_r      <= start_x_nxt;
      row_r      <= start_y_nxt;
      line_col_r <= start_x_nxt;
      box_r      <= '{any: 1'b0, min_col: start_x_nxt, min_row: start_y_nxt,
                      max_col: start_x_nxt, max_row: start_y_nxt};
    end else begin
      tiles_r    <= tiles_nxt;
      pix_r      <= pix_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      line_col_r <= line_col_nxt;
      box_r      <= box_nxt;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step && emit) out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_tiles_r <= tiles_r + {7'd0, (pix_r != 3'd0)};
      out_x_r     <= box_r.any ? box_r.min_col : start_x_r;
      out_y_r     <= box_r.any ? box_r.min_row : start_y_r;
      out_w_r     <= box_r.any ? (box_r.max_col - box_r.min_col) : 8'd0;
      out_h_r     <= box_r.any ? (box_r.max_row - box_r.min_row) : 8'd0;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.tiles_used = out_tiles_r;
  assign out_chan.box_x      = out_x_r;
  assign out_chan.box_y      = out_y_r;
  assign out_chan.box_width  = out_w_r;
  assign out_chan.box_height = out_h_r;

  // a new result only comes from a terminating byte in the last stage
  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(emit && advance))
    else $error("result raised without a terminating byte");

  // input is held back only while a result waits
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |-> out_valid_r)
    else $error("input stalled with empty output register");

  // a fixed-width glyph leaves no partial tile
  a_fixed_glyph_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (step && s2_op_r == OP_GLYPH && !s2_prop_r) |=> (pix_r == 3'd0))
    else $error("partial tile left after fixed glyph");

  // an untouched box sits at the start point
  a_empty_box_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    !box_r.any |-> (box_r.min_col == start_x_r && box_r.max_col == start_x_r &&
                    box_r.min_row == start_y_r && box_r.max_row == start_y_r))
    else $error("empty box away from start");

endmodule
